>>> rtl/pdil_pkg.sv
// Package of types and constants for the priority dispatcher.
package pdil_pkg;

	localparam int NumClasses = 3;
	localparam int QueueDepthDefault = 16;
	localparam int EarlyListDepthDefault = 8;
	localparam int HandleBits = 16;
	localparam int SeqBits = 32;
	localparam int LimitBits = 7;
	localparam int CfgIndexBits = 2;
	localparam int FifoDepth = 2;

	localparam logic [LimitBits-1:0] LimitHighReset = 7'd0;
	localparam logic [LimitBits-1:0] LimitMediumReset = 7'd2;
	localparam logic [LimitBits-1:0] LimitLowReset = 7'd1;

	typedef enum logic [1:0] {
		ACT_ISSUE = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_DONE = 2'd2,
		ACT_UNUSED = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NONE = 2'd1,
		ST_QFULL = 2'd2,
		ST_LFULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_LIMIT_HIGH = 2'd0,
		CFG_LIMIT_MEDIUM = 2'd1,
		CFG_LIMIT_LOW = 2'd2,
		CFG_NONE = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_READ,
		EX_SCAN,
		EX_WAIT,
		EX_OUT
	} ex_state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] priority_req;
		logic [HandleBits-1:0] request_handle;
		logic [SeqBits-1:0] done_number;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] granted_class;
		logic [HandleBits-1:0] granted_handle;
		logic [SeqBits-1:0] seq_number;
		logic [SeqBits-1:0] processed_number;
	} out_beat_t;

endpackage

>>> rtl/pdil_ram.sv
// Generic single-port-write, registered-read memory.
module pdil_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/pdil_front.sv
// Front part: a short queue of accepted input beats.
module pdil_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input pdil_pkg::in_beat_t in_beat,
	output logic cmd_valid,
	input logic cmd_take,
	output pdil_pkg::in_beat_t cmd
);

	localparam int Ptr = $clog2(pdil_pkg::FifoDepth);

	pdil_pkg::in_beat_t buf_q [pdil_pkg::FifoDepth];
	logic [Ptr-1:0] rd_q, wr_q;
	logic [Ptr:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (Ptr+1)'(pdil_pkg::FifoDepth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Ptr+1)'(do_push) - (Ptr+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= in_beat;
		end
	end

endmodule

>>> rtl/pdil_back.sv
// Back part: queues, counters and completion list, handled one beat at a time.
module pdil_back #(
	parameter int QueueDepth = pdil_pkg::QueueDepthDefault,
	parameter int EarlyListDepth = pdil_pkg::EarlyListDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pdil_pkg::CfgIndexBits-1:0] cfg_index,
	input logic [pdil_pkg::LimitBits-1:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_take,
	input pdil_pkg::in_beat_t cmd,
	output logic empty,
	input logic pop,
	output pdil_pkg::out_beat_t out_beat
);

	localparam int HandleBits = pdil_pkg::HandleBits;
	localparam int SeqBits = pdil_pkg::SeqBits;
	localparam int NC = pdil_pkg::NumClasses;
	localparam int QA = $clog2(QueueDepth);
	localparam int LA = (EarlyListDepth > 1) ? $clog2(EarlyListDepth) : 1;
	localparam int MemDepth = NC * QueueDepth;
	localparam int MA = $clog2(MemDepth);

	typedef logic [SeqBits-1:0] seq_t;

	logic [pdil_pkg::LimitBits-1:0] limit_q [NC];
	logic [QA-1:0] head_q [NC];
	logic [QA:0] count_q [NC];
	seq_t issued_q [NC], disp_q [NC], proc_q [NC];
	seq_t list_q [NC][EarlyListDepth];
	logic [EarlyListDepth-1:0] lvalid_q [NC];

	pdil_pkg::ex_state_t state_q, state_d;
	pdil_pkg::in_beat_t cmd_q;
	pdil_pkg::out_beat_t res_q;
	pdil_pkg::out_beat_t out_q;
	pdil_pkg::out_beat_t read_res;
	logic res_full_q;
	logic [LA-1:0] idx_q;
	logic found_q;

	logic mem_we;
	logic [MA-1:0] mem_waddr, mem_raddr;
	logic [HandleBits-1:0] mem_rdata;

	function automatic seq_t seq_next(seq_t v);
		seq_t n;
		n = v + 1'b1;
		if (n == '0) begin
			n = seq_t'(1);
		end
		return n;
	endfunction

	function automatic seq_t in_flight(seq_t d, seq_t p);
		seq_t diff;
		diff = d - p;
		if (d < p && diff != '0) begin
			diff = diff - 1'b1;
		end
		return diff;
	endfunction

	function automatic logic [MA-1:0] maddr(logic [1:0] c, logic [QA-1:0] s);
		return MA'(c) * MA'(QueueDepth) + MA'(s);
	endfunction

	logic [1:0] pick;
	logic pick_ok;
	always_comb begin
		pick = 2'd0;
		pick_ok = 1'b0;
		for (int c = NC - 1; c >= 0; c--) begin
			if (count_q[c] != '0 &&
					in_flight(disp_q[c], proc_q[c]) < seq_t'(limit_q[c])) begin
				pick = 2'(c);
				pick_ok = 1'b1;
			end
		end
	end

	logic [1:0] ccls;
	logic [QA:0] tail_sum;
	logic [QA-1:0] tail;
	assign ccls = cmd_q.priority_req;
	assign tail_sum = {1'b0, head_q[ccls]} + count_q[ccls];
	assign tail = (tail_sum >= (QA+1)'(QueueDepth)) ?
		QA'(tail_sum - (QA+1)'(QueueDepth)) : QA'(tail_sum);

	logic free_ok;
	logic [LA-1:0] free_idx;
	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = EarlyListDepth - 1; i >= 0; i--) begin
			if (!lvalid_q[ccls][i]) begin
				free_ok = 1'b1;
				free_idx = LA'(i);
			end
		end
	end

	logic hit;
	seq_t want;
	assign want = seq_next(proc_q[ccls]);
	assign hit = lvalid_q[ccls][idx_q] && (list_q[ccls][idx_q] == want);

	logic last_idx;
	assign last_idx = (idx_q == LA'(EarlyListDepth - 1));

	assign cmd_take = (state_q == pdil_pkg::EX_IDLE) && cmd_valid;
	assign empty = !res_full_q;
	assign out_beat = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdil_pkg::EX_IDLE: begin
				if (cmd_valid) begin
					state_d = pdil_pkg::EX_READ;
				end
			end
			pdil_pkg::EX_READ: begin
				if (cmd_q.action == pdil_pkg::ACT_DISPATCH && pick_ok) begin
					state_d = pdil_pkg::EX_WAIT;
				end else if (cmd_q.action == pdil_pkg::ACT_DONE && ccls != 2'd3 &&
						want == SeqBits'(cmd_q.done_number)) begin
					state_d = pdil_pkg::EX_SCAN;
				end else begin
					state_d = pdil_pkg::EX_OUT;
				end
			end
			pdil_pkg::EX_SCAN: begin
				if (last_idx && !hit && !found_q) begin
					state_d = pdil_pkg::EX_OUT;
				end
			end
			pdil_pkg::EX_WAIT: state_d = pdil_pkg::EX_OUT;
			pdil_pkg::EX_OUT: begin
				if (!res_full_q || pop) begin
					state_d = pdil_pkg::EX_IDLE;
				end
			end
			default: state_d = pdil_pkg::EX_IDLE;
		endcase
	end

	always_comb begin
		mem_we = (state_q == pdil_pkg::EX_READ) && cmd_q.action == pdil_pkg::ACT_ISSUE &&
			ccls != 2'd3 && count_q[ccls] < (QA+1)'(QueueDepth);
		mem_waddr = maddr(ccls, tail);
		mem_raddr = maddr(pick, head_q[pick]);
	end

	always_comb begin
		read_res = '0;
		read_res.status = pdil_pkg::ST_NONE;
		if (cmd_q.action == pdil_pkg::ACT_ISSUE && ccls != 2'd3) begin
			if (count_q[ccls] < (QA+1)'(QueueDepth)) begin
				read_res.seq_number = seq_next(issued_q[ccls]);
				read_res.status = pdil_pkg::ST_OK;
			end else begin
				read_res.status = pdil_pkg::ST_QFULL;
			end
		end else if (cmd_q.action == pdil_pkg::ACT_DISPATCH && pick_ok) begin
			read_res.seq_number = seq_next(disp_q[pick]);
			read_res.granted_class = pick;
			read_res.status = pdil_pkg::ST_OK;
		end else if (cmd_q.action == pdil_pkg::ACT_DONE && ccls != 2'd3) begin
			if (want == SeqBits'(cmd_q.done_number)) begin
				read_res.status = pdil_pkg::ST_OK;
			end else begin
				read_res.processed_number = proc_q[ccls];
				read_res.status = free_ok ? pdil_pkg::ST_OK : pdil_pkg::ST_LFULL;
			end
		end
	end

	pdil_ram #(.Width(HandleBits), .Depth(MemDepth)) u_queue_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(HandleBits'(cmd_q.request_handle)),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdil_pkg::EX_IDLE;
			res_full_q <= 1'b0;
			limit_q[0] <= pdil_pkg::LimitHighReset;
			limit_q[1] <= pdil_pkg::LimitMediumReset;
			limit_q[2] <= pdil_pkg::LimitLowReset;
			for (int c = 0; c < NC; c++) begin
				head_q[c] <= '0;
				count_q[c] <= '0;
				issued_q[c] <= '0;
				disp_q[c] <= '0;
				proc_q[c] <= '0;
				lvalid_q[c] <= '0;
			end
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index != pdil_pkg::CFG_NONE) begin
				limit_q[cfg_index] <= cfg_data;
			end
			if (state_q == pdil_pkg::EX_OUT && (!res_full_q || pop)) begin
				res_full_q <= 1'b1;
				out_q <= res_q;
			end else if (res_full_q && pop) begin
				res_full_q <= 1'b0;
			end
			case (state_q)
				pdil_pkg::EX_READ: begin
					idx_q <= '0;
					found_q <= 1'b0;
					res_q <= read_res;
					if (cmd_q.action == pdil_pkg::ACT_ISSUE && ccls != 2'd3) begin
						if (mem_we) begin
							count_q[ccls] <= count_q[ccls] + 1'b1;
							issued_q[ccls] <= seq_next(issued_q[ccls]);
						end
					end else if (cmd_q.action == pdil_pkg::ACT_DISPATCH && pick_ok) begin
						head_q[pick] <= (head_q[pick] == QA'(QueueDepth - 1)) ? '0 :
							head_q[pick] + 1'b1;
						count_q[pick] <= count_q[pick] - 1'b1;
						disp_q[pick] <= seq_next(disp_q[pick]);
					end else if (cmd_q.action == pdil_pkg::ACT_DONE && ccls != 2'd3) begin
						if (want == SeqBits'(cmd_q.done_number)) begin
							proc_q[ccls] <= want;
						end else if (free_ok) begin
							list_q[ccls][free_idx] <= SeqBits'(cmd_q.done_number);
							lvalid_q[ccls][free_idx] <= 1'b1;
						end
					end
				end
				pdil_pkg::EX_SCAN: begin
					if (hit) begin
						proc_q[ccls] <= want;
						lvalid_q[ccls][idx_q] <= 1'b0;
						found_q <= 1'b1;
					end
					if (hit || last_idx) begin
						idx_q <= '0;
						if (!hit) begin
							found_q <= 1'b0;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					if (last_idx && !hit && !found_q) begin
						res_q.processed_number <= proc_q[ccls];
					end
				end
				pdil_pkg::EX_WAIT: begin
					res_q.granted_handle <= mem_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pdil_pkg::EX_WAIT |-> $past(state_q) == pdil_pkg::EX_READ)
		else $error("wait state not entered from read");
	for (genvar c = 0; c < NC; c++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			count_q[c] <= (QA+1)'(QueueDepth))
			else $error("queue fill count beyond depth");
	end
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> state_q == pdil_pkg::EX_IDLE)
		else $error("beat taken while busy");
`endif

endmodule

>>> rtl/priority_dispatch_with_inflight_limits_top.sv
// Top level of the strict-priority dispatcher with in-flight limits.
// Beats enter through a two-entry input queue and are executed one at a time.
// The back part takes an issue, a refused beat or an out-of-order completion
// through its read and output states, and a dispatch through its read, wait and
// output states, the wait state covering the registered read of the handle memory.
// An in-order completion scans the early-done list one entry a cycle, restarting
// after each absorbed number and ending with a pass that finds nothing. A finished
// result moves into an output register, so the next beat is worked on while it
// waits; the back part stalls only when a second result is ready before the first
// has been popped.
module priority_dispatch_with_inflight_limits_top #(
	parameter int QueueDepth = pdil_pkg::QueueDepthDefault,
	parameter int EarlyListDepth = pdil_pkg::EarlyListDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input pdil_pkg::in_beat_t in_beat,
	output logic empty,
	input logic pop,
	output pdil_pkg::out_beat_t out_beat,
	input logic cfg_we,
	input logic [pdil_pkg::CfgIndexBits-1:0] cfg_index,
	input logic [pdil_pkg::LimitBits-1:0] cfg_data
);

	logic cmd_valid, cmd_take;
	pdil_pkg::in_beat_t cmd;

	pdil_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_beat(in_beat),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd)
	);

	pdil_back #(
		.QueueDepth(QueueDepth),
		.EarlyListDepth(EarlyListDepth)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd),
		.empty(empty),
		.pop(pop),
		.out_beat(out_beat)
	);

endmodule

>>> tb/priority_dispatch_with_inflight_limits_top_test.sv
// Self-checking testbench for the strict-priority dispatcher with in-flight limits.
module priority_dispatch_with_inflight_limits_top_test;

	localparam logic [1:0] CLS_HIGH = 2'd0;
	localparam logic [1:0] CLS_MEDIUM = 2'd1;
	localparam logic [1:0] CLS_LOW = 2'd2;
	localparam logic [1:0] CLS_UNUSED = 2'd3;
	localparam int QDepth = 16;
	localparam int ListDepth = 8;
	localparam int SettleCycles = 120;
	localparam int CycleLimit = 900000;

	class dispatch_scoreboard;
		logic [pdil_pkg::LimitBits-1:0] limit[pdil_pkg::NumClasses];
		logic [15:0] handles[pdil_pkg::NumClasses][QDepth];
		int head[pdil_pkg::NumClasses];
		int fill[pdil_pkg::NumClasses];
		logic [31:0] issued[pdil_pkg::NumClasses];
		logic [31:0] dispatched[pdil_pkg::NumClasses];
		logic [31:0] processed[pdil_pkg::NumClasses];
		logic [31:0] early[pdil_pkg::NumClasses][ListDepth];
		bit early_ok[pdil_pkg::NumClasses][ListDepth];
		pdil_pkg::out_beat_t awaited[$];
		int errors;
		int beats_checked;
		int grants;
		int refusals;

		function new();
			limit[0] = pdil_pkg::LimitHighReset;
			limit[1] = pdil_pkg::LimitMediumReset;
			limit[2] = pdil_pkg::LimitLowReset;
			for (int c = 0; c < pdil_pkg::NumClasses; c++) begin
				head[c] = 0;
				fill[c] = 0;
				issued[c] = '0;
				dispatched[c] = '0;
				processed[c] = '0;
				for (int i = 0; i < ListDepth; i++) early_ok[c][i] = 0;
			end
			errors = 0;
			beats_checked = 0;
			grants = 0;
			refusals = 0;
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			logic [31:0] n;
			n = v + 32'd1;
			return (n == 32'd0) ? 32'd1 : n;
		endfunction

		function logic [31:0] outstanding(int c);
			logic [31:0] diff;
			diff = dispatched[c] - processed[c];
			if (dispatched[c] < processed[c] && diff > 0) diff = diff - 32'd1;
			return diff;
		endfunction

		function void set_limit(pdil_pkg::cfg_index_t idx, logic [pdil_pkg::LimitBits-1:0] v);
			if (idx != pdil_pkg::CFG_NONE) limit[idx] = v;
		endfunction

		function void note_beat(pdil_pkg::in_beat_t b);
			pdil_pkg::out_beat_t r;
			int c;
			bit found;
			r = '0;
			r.status = pdil_pkg::ST_NONE;
			c = b.priority_req;
			if (b.action == pdil_pkg::ACT_ISSUE && b.priority_req != CLS_UNUSED) begin
				if (fill[c] >= QDepth) begin
					r.status = pdil_pkg::ST_QFULL;
				end else begin
					handles[c][(head[c] + fill[c]) % QDepth] = b.request_handle;
					fill[c]++;
					issued[c] = bump(issued[c]);
					r.seq_number = issued[c];
					r.status = pdil_pkg::ST_OK;
				end
			end else if (b.action == pdil_pkg::ACT_DISPATCH) begin
				for (c = 0; c < pdil_pkg::NumClasses; c++)
					if (fill[c] != 0 && outstanding(c) < {25'd0, limit[c]}) break;
				if (c < pdil_pkg::NumClasses) begin
					r.granted_handle = handles[c][head[c]];
					head[c] = (head[c] + 1) % QDepth;
					fill[c]--;
					dispatched[c] = bump(dispatched[c]);
					r.seq_number = dispatched[c];
					r.granted_class = c[1:0];
					r.status = pdil_pkg::ST_OK;
					grants++;
				end
			end else if (b.action == pdil_pkg::ACT_DONE && b.priority_req != CLS_UNUSED) begin
				if (bump(processed[c]) == b.done_number) begin
					processed[c] = b.done_number;
					found = 1;
					while (found) begin
						found = 0;
						for (int i = 0; i < ListDepth; i++) begin
							if (!found && early_ok[c][i] &&
									early[c][i] == bump(processed[c])) begin
								processed[c] = early[c][i];
								early_ok[c][i] = 0;
								found = 1;
							end
						end
					end
					r.status = pdil_pkg::ST_OK;
				end else begin
					r.status = pdil_pkg::ST_LFULL;
					for (int i = 0; i < ListDepth; i++) begin
						if (r.status == pdil_pkg::ST_LFULL && !early_ok[c][i]) begin
							early[c][i] = b.done_number;
							early_ok[c][i] = 1;
							r.status = pdil_pkg::ST_OK;
						end
					end
				end
				r.processed_number = processed[c];
			end
			if (r.status == pdil_pkg::ST_QFULL || r.status == pdil_pkg::ST_LFULL) refusals++;
			awaited = {awaited, r};
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(pdil_pkg::out_beat_t got);
			pdil_pkg::out_beat_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result beat %0h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			beats_checked++;
			compare("status", 32'(want.status), 32'(got.status));
			compare("granted_class", 32'(want.granted_class), 32'(got.granted_class));
			compare("granted_handle", 32'(want.granted_handle), 32'(got.granted_handle));
			compare("seq_number", want.seq_number, got.seq_number);
			compare("processed_number", want.processed_number, got.processed_number);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	pdil_pkg::in_beat_t in_beat = '0;
	logic empty;
	logic pop = 0;
	pdil_pkg::out_beat_t out_beat;
	logic cfg_we = 0;
	logic [pdil_pkg::CfgIndexBits-1:0] cfg_index = '0;
	logic [pdil_pkg::LimitBits-1:0] cfg_data = '0;

	dispatch_scoreboard tracker = new();
	bit calm = 0;
	int junk_pct = 5;
	int cycles = 0;

	priority_dispatch_with_inflight_limits_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_beat(in_beat),
		.empty(empty), .pop(pop), .out_beat(out_beat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && pop && !empty) tracker.check_beat(out_beat);
		if (cycles > CycleLimit) begin
			$display("Timed out after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= arst_n && (calm || $urandom_range(99) >= 20);
	end

	task automatic send(pdil_pkg::action_t act, logic [1:0] cls, logic [15:0] h,
			logic [31:0] num);
		if (!calm && $urandom_range(99) < 20) begin
			push = 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		push = 1;
		in_beat.action = act;
		in_beat.priority_req = cls;
		in_beat.request_handle = h;
		in_beat.done_number = num;
		do @(posedge clk); while (full);
		tracker.note_beat(in_beat);
		@(negedge clk);
		push = 0;
	endtask

	task automatic settle();
		while (tracker.awaited.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_limit(pdil_pkg::cfg_index_t idx, logic [pdil_pkg::LimitBits-1:0] v);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		tracker.set_limit(idx, v);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_beat();
		int pick;
		logic [1:0] cls;
		logic [31:0] num;
		pick = $urandom_range(99);
		cls = 2'($urandom_range(2));
		if (pick < 35) begin
			send(pdil_pkg::ACT_ISSUE, cls, 16'($urandom), $urandom);
		end else if (pick < 68) begin
			send(pdil_pkg::ACT_DISPATCH, 2'($urandom), 16'($urandom), $urandom);
		end else if (pick < 95) begin
			if ($urandom_range(99) < junk_pct) num = $urandom;
			else num = tracker.processed[cls] + 32'($urandom_range(3, 1));
			send(pdil_pkg::ACT_DONE, cls, 16'($urandom), num);
		end else if (pick < 97) begin
			send(pdil_pkg::ACT_UNUSED, 2'($urandom), 16'($urandom), $urandom);
		end else begin
			send($urandom_range(1) ? pdil_pkg::ACT_ISSUE : pdil_pkg::ACT_DONE, CLS_UNUSED,
				16'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// High class is blocked at reset, so its queue fills up.
		for (int i = 0; i < QDepth + 1; i++)
			send(pdil_pkg::ACT_ISSUE, CLS_HIGH, 16'(i * 4099), 32'd0);
		send(pdil_pkg::ACT_DISPATCH, CLS_HIGH, 16'hFFFF, 32'hFFFF_FFFF);
		send(pdil_pkg::ACT_ISSUE, CLS_MEDIUM, 16'hFFFF, 32'hFFFF_FFFF);
		send(pdil_pkg::ACT_ISSUE, CLS_LOW, 16'h0000, 32'd0);
		send(pdil_pkg::ACT_DISPATCH, CLS_HIGH, 16'h0, 32'd0);
		send(pdil_pkg::ACT_DISPATCH, CLS_HIGH, 16'h0, 32'd0);
		send(pdil_pkg::ACT_DONE, CLS_LOW, 16'h0, 32'd1);
		send(pdil_pkg::ACT_DONE, CLS_MEDIUM, 16'h0, 32'd3);
		send(pdil_pkg::ACT_DONE, CLS_MEDIUM, 16'h0, 32'd0);
		send(pdil_pkg::ACT_DONE, CLS_MEDIUM, 16'h0, 32'd2);
		send(pdil_pkg::ACT_DONE, CLS_MEDIUM, 16'h0, 32'd1);
		send(pdil_pkg::ACT_UNUSED, CLS_LOW, 16'h1234, 32'd5);
		send(pdil_pkg::ACT_ISSUE, CLS_UNUSED, 16'h1234, 32'd5);
		send(pdil_pkg::ACT_DONE, CLS_UNUSED, 16'h1234, 32'd1);

		for (int phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: begin
					write_limit(pdil_pkg::CFG_LIMIT_HIGH, 7'd64);
					write_limit(pdil_pkg::CFG_LIMIT_MEDIUM, 7'd64);
					write_limit(pdil_pkg::CFG_LIMIT_LOW, 7'd64);
				end
				1: begin
					write_limit(pdil_pkg::CFG_LIMIT_HIGH, 7'd1);
					write_limit(pdil_pkg::CFG_LIMIT_MEDIUM, 7'd0);
					write_limit(pdil_pkg::CFG_LIMIT_LOW, 7'd3);
					write_limit(pdil_pkg::CFG_NONE, 7'h7F);
				end
				2: begin
					write_limit(pdil_pkg::CFG_LIMIT_HIGH, 7'd0);
					write_limit(pdil_pkg::CFG_LIMIT_LOW, 7'd0);
				end
				3: begin
					write_limit(pdil_pkg::CFG_LIMIT_HIGH, 7'd2);
					write_limit(pdil_pkg::CFG_LIMIT_MEDIUM, 7'd5);
					write_limit(pdil_pkg::CFG_LIMIT_LOW, 7'd64);
				end
				4: begin
					write_limit(pdil_pkg::CFG_LIMIT_HIGH, 7'd127);
					write_limit(pdil_pkg::CFG_LIMIT_MEDIUM, 7'd127);
					write_limit(pdil_pkg::CFG_LIMIT_LOW, 7'd127);
				end
				default: begin
					write_limit(pdil_pkg::CFG_LIMIT_HIGH, 7'($urandom_range(4)));
					write_limit(pdil_pkg::CFG_LIMIT_MEDIUM, 7'($urandom_range(4)));
					write_limit(pdil_pkg::CFG_LIMIT_LOW, 7'($urandom_range(4)));
				end
			endcase
			calm = (phase == 3);
			junk_pct = (phase == 4) ? 40 : 5;
			for (int i = 0; i < 215; i++) random_beat();
		end

		calm = 0;
		settle();
		$display("Checked %0d result beats over six limit settings: %0d grants, %0d refusals.",
			tracker.beats_checked, tracker.grants, tracker.refusals);
		if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d beats still awaited", tracker.errors,
				tracker.awaited.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> priority_dispatch_with_inflight_limits_top.f
rtl/pdil_pkg.sv
rtl/pdil_ram.sv
rtl/pdil_front.sv
rtl/pdil_back.sv
rtl/priority_dispatch_with_inflight_limits_top.sv
tb/priority_dispatch_with_inflight_limits_top_test.sv
